// ----- rtl/sws_pkg.sv -----
// Shared types and constants for the single-wire byte slave.
package sws_pkg;

    localparam int BITS_PER_FRAME = 8;
    localparam int DELAY_WIDTH    = 16;
    localparam int CFG_WIDTH      = 16;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [2:0] TOP_BIT = 3'((BITS_PER_FRAME - 1) & 7);

    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_WAIT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RECEIVE_WAIT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_WAIT  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE_WAIT = 2'd3;

    localparam int RST_SHORT_WAIT    = 10;
    localparam int RST_RECEIVE_WAIT  = 15;
    localparam int RST_COMMAND_WAIT  = 55;
    localparam int RST_PREAMBLE_WAIT = 100;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_TX   = 2'd1;
    localparam logic [1:0] KIND_RX   = 2'd2;

    typedef enum logic [20:0] {
        PH_IDLE        = 21'h000001,
        PH_WAIT_RISE   = 21'h000002,
        PH_CMD_A       = 21'h000004,
        PH_CMD_B_RD    = 21'h000008,
        PH_CMD_B_WR    = 21'h000010,
        PH_FALL_RD     = 21'h000020,
        PH_FALL_WR     = 21'h000040,
        PH_RX_LOW      = 21'h000080,
        PH_RX_HIGH     = 21'h000100,
        PH_RX_SAMPLE   = 21'h000200,
        PH_RX_HOLD     = 21'h000400,
        PH_RX_END_HIGH = 21'h000800,
        PH_RX_FINAL    = 21'h001000,
        PH_TX_PRE      = 21'h002000,
        PH_TX_L1       = 21'h004000,
        PH_TX_H1       = 21'h008000,
        PH_TX_L2       = 21'h010000,
        PH_TX_BIT      = 21'h020000,
        PH_TX_TAIL_H   = 21'h040000,
        PH_TX_TAIL_L   = 21'h080000,
        PH_TX_TAIL_H2  = 21'h100000
    } t_phase;

    typedef struct packed {
        logic       drive_enable;
        logic       drive_level;
        logic       byte_written;
        logic [7:0] stored_byte;
        logic [1:0] last_kind;
    } t_result;

endpackage

// ----- rtl/sws_cfg.sv -----
// Timing configuration registers of the single-wire byte slave.
module sws_cfg #(
    parameter int DELAY_WIDTH = sws_pkg::DELAY_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [sws_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [sws_pkg::CFG_WIDTH-1:0]       i_cfg_wdata,
    output logic [DELAY_WIDTH-1:0]              o_short_wait,
    output logic [DELAY_WIDTH-1:0]              o_receive_wait,
    output logic [DELAY_WIDTH-1:0]              o_command_wait,
    output logic [DELAY_WIDTH-1:0]              o_preamble_wait
);

    logic [DELAY_WIDTH-1:0] r_short_wait;
    logic [DELAY_WIDTH-1:0] r_receive_wait;
    logic [DELAY_WIDTH-1:0] r_command_wait;
    logic [DELAY_WIDTH-1:0] r_preamble_wait;
    logic [DELAY_WIDTH-1:0] n_value;

    assign n_value = DELAY_WIDTH'(i_cfg_wdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_wait    <= DELAY_WIDTH'(sws_pkg::RST_SHORT_WAIT);
            r_receive_wait  <= DELAY_WIDTH'(sws_pkg::RST_RECEIVE_WAIT);
            r_command_wait  <= DELAY_WIDTH'(sws_pkg::RST_COMMAND_WAIT);
            r_preamble_wait <= DELAY_WIDTH'(sws_pkg::RST_PREAMBLE_WAIT);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                sws_pkg::REG_SHORT_WAIT: begin
                    r_short_wait <= n_value;
                end
                sws_pkg::REG_RECEIVE_WAIT: begin
                    r_receive_wait <= n_value;
                end
                sws_pkg::REG_COMMAND_WAIT: begin
                    r_command_wait <= n_value;
                end
                sws_pkg::REG_PREAMBLE_WAIT: begin
                    r_preamble_wait <= n_value;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_short_wait    = r_short_wait;
    assign o_receive_wait  = r_receive_wait;
    assign o_command_wait  = r_command_wait;
    assign o_preamble_wait = r_preamble_wait;

endmodule

// ----- rtl/sws_core.sv -----
// Frame state machine of the single-wire byte slave, one tick per step.
module sws_core #(
    parameter int DELAY_WIDTH = sws_pkg::DELAY_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic                   i_line,
    input  logic [DELAY_WIDTH-1:0] i_short_wait,
    input  logic [DELAY_WIDTH-1:0] i_receive_wait,
    input  logic [DELAY_WIDTH-1:0] i_command_wait,
    input  logic [DELAY_WIDTH-1:0] i_preamble_wait,
    output sws_pkg::t_result       o_result
);

    sws_pkg::t_phase        r_phase;
    sws_pkg::t_phase        n_phase;
    logic [DELAY_WIDTH-1:0] r_tick;
    logic [DELAY_WIDTH-1:0] n_tick;
    logic [2:0]             r_bit;
    logic [2:0]             n_bit;
    logic [7:0]             r_held;
    logic [7:0]             n_held;
    logic [1:0]             r_kind;
    logic [1:0]             n_kind;
    logic                   n_written;
    logic [DELAY_WIDTH-1:0] w_wait;
    logic [DELAY_WIDTH-1:0] w_inc;
    logic                   w_done;

    always_comb begin
        case (r_phase)
            sws_pkg::PH_CMD_A, sws_pkg::PH_CMD_B_RD, sws_pkg::PH_CMD_B_WR: begin
                w_wait = i_command_wait;
            end
            sws_pkg::PH_RX_SAMPLE, sws_pkg::PH_RX_HOLD: begin
                w_wait = i_receive_wait;
            end
            sws_pkg::PH_TX_PRE: begin
                w_wait = i_preamble_wait;
            end
            default: begin
                w_wait = i_short_wait;
            end
        endcase
    end

    assign w_inc  = (r_tick != {DELAY_WIDTH{1'b1}}) ? r_tick + 1'b1 : r_tick;
    assign w_done = (w_inc >= w_wait);

    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_bit     = r_bit;
        n_held    = r_held;
        n_kind    = r_kind;
        n_written = 1'b0;
        case (r_phase)
            sws_pkg::PH_WAIT_RISE: begin
                if (i_line) begin
                    n_phase = sws_pkg::PH_CMD_A;
                    n_tick  = '0;
                end
            end
            sws_pkg::PH_CMD_A: begin
                n_tick = w_inc;
                if (w_done) begin
                    n_phase = i_line ? sws_pkg::PH_CMD_B_RD : sws_pkg::PH_CMD_B_WR;
                    n_tick  = '0;
                end
            end
            sws_pkg::PH_CMD_B_RD: begin
                n_tick = w_inc;
                if (w_done) begin
                    n_phase = sws_pkg::PH_FALL_RD;
                    n_tick  = '0;
                end
            end
            sws_pkg::PH_CMD_B_WR: begin
                n_tick = w_inc;
                if (w_done) begin
                    n_phase = sws_pkg::PH_FALL_WR;
                    n_tick  = '0;
                end
            end
            sws_pkg::PH_FALL_RD: begin
                if (!i_line) begin
                    n_kind  = sws_pkg::KIND_TX;
                    n_bit   = sws_pkg::TOP_BIT;
                    n_phase = sws_pkg::PH_TX_PRE;
                    n_tick  = '0;
                end
            end
            sws_pkg::PH_FALL_WR: begin
                if (!i_line) begin
                    n_kind  = sws_pkg::KIND_RX;
                    n_held  = '0;
                    n_bit   = sws_pkg::TOP_BIT;
                    n_phase = sws_pkg::PH_RX_LOW;
                    n_tick  = '0;
                end
            end
            sws_pkg::PH_RX_LOW: begin
                if (i_line) begin
                    n_phase = sws_pkg::PH_RX_HIGH;
                    n_tick  = '0;
                end
            end
            sws_pkg::PH_RX_HIGH: begin
                if (!i_line) begin
                    n_phase = sws_pkg::PH_RX_SAMPLE;
                    n_tick  = '0;
                end
            end
            sws_pkg::PH_RX_SAMPLE: begin
                n_tick = w_inc;
                if (w_done) begin
                    if (i_line) begin
                        n_held[r_bit] = 1'b1;
                    end
                    n_phase = sws_pkg::PH_RX_HOLD;
                    n_tick  = '0;
                end
            end
            sws_pkg::PH_RX_HOLD: begin
                n_tick = w_inc;
                if (w_done) begin
                    n_phase = sws_pkg::PH_RX_END_HIGH;
                    n_tick  = '0;
                end
            end
            sws_pkg::PH_RX_END_HIGH: begin
                if (!i_line) begin
                    n_tick = '0;
                    if (r_bit == 3'd0) begin
                        n_phase = sws_pkg::PH_RX_FINAL;
                    end else begin
                        n_bit   = r_bit - 3'd1;
                        n_phase = sws_pkg::PH_RX_LOW;
                    end
                end
            end
            sws_pkg::PH_RX_FINAL: begin
                if (i_line) begin
                    n_written = 1'b1;
                    n_bit     = sws_pkg::TOP_BIT;
                    n_phase   = sws_pkg::PH_IDLE;
                    n_tick    = '0;
                end
            end
            sws_pkg::PH_TX_PRE: begin
                n_tick = w_inc;
                if (w_done) begin
                    n_phase = sws_pkg::PH_TX_L1;
                    n_tick  = '0;
                end
            end
            sws_pkg::PH_TX_L1: begin
                n_tick = w_inc;
                if (w_done) begin
                    n_phase = sws_pkg::PH_TX_H1;
                    n_tick  = '0;
                end
            end
            sws_pkg::PH_TX_H1: begin
                n_tick = w_inc;
                if (w_done) begin
                    n_phase = sws_pkg::PH_TX_L2;
                    n_tick  = '0;
                end
            end
            sws_pkg::PH_TX_L2: begin
                n_tick = w_inc;
                if (w_done) begin
                    n_phase = sws_pkg::PH_TX_BIT;
                    n_tick  = '0;
                end
            end
            sws_pkg::PH_TX_BIT: begin
                n_tick = w_inc;
                if (w_done) begin
                    n_tick = '0;
                    if (r_bit == 3'd0) begin
                        n_phase = sws_pkg::PH_TX_TAIL_H;
                    end else begin
                        n_bit   = r_bit - 3'd1;
                        n_phase = sws_pkg::PH_TX_L1;
                    end
                end
            end
            sws_pkg::PH_TX_TAIL_H: begin
                n_tick = w_inc;
                if (w_done) begin
                    n_phase = sws_pkg::PH_TX_TAIL_L;
                    n_tick  = '0;
                end
            end
            sws_pkg::PH_TX_TAIL_L: begin
                n_tick = w_inc;
                if (w_done) begin
                    n_phase = sws_pkg::PH_TX_TAIL_H2;
                    n_tick  = '0;
                end
            end
            sws_pkg::PH_TX_TAIL_H2: begin
                n_tick = w_inc;
                if (w_done) begin
                    n_bit   = sws_pkg::TOP_BIT;
                    n_phase = sws_pkg::PH_IDLE;
                    n_tick  = '0;
                end
            end
            default: begin
                // Idle, and any corrupted phase code, waits for a low line.
                n_phase = sws_pkg::PH_IDLE;
                if (!i_line) begin
                    n_kind  = sws_pkg::KIND_NONE;
                    n_phase = sws_pkg::PH_WAIT_RISE;
                    n_tick  = '0;
                end
            end
        endcase
    end

    always_comb begin
        o_result.drive_enable = 1'b0;
        o_result.drive_level  = 1'b0;
        case (n_phase)
            sws_pkg::PH_TX_PRE, sws_pkg::PH_TX_H1,
            sws_pkg::PH_TX_TAIL_H, sws_pkg::PH_TX_TAIL_H2: begin
                o_result.drive_enable = 1'b1;
                o_result.drive_level  = 1'b1;
            end
            sws_pkg::PH_TX_L1, sws_pkg::PH_TX_L2, sws_pkg::PH_TX_TAIL_L: begin
                o_result.drive_enable = 1'b1;
            end
            sws_pkg::PH_TX_BIT: begin
                o_result.drive_enable = 1'b1;
                o_result.drive_level  = n_held[n_bit];
            end
            default: begin
            end
        endcase
        o_result.byte_written = n_written;
        o_result.stored_byte  = n_held;
        o_result.last_kind    = n_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sws_pkg::PH_IDLE;
            r_tick  <= '0;
            r_bit   <= sws_pkg::TOP_BIT;
            r_held  <= '0;
            r_kind  <= sws_pkg::KIND_NONE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_held  <= n_held;
            r_kind  <= n_kind;
        end
    end

endmodule

// ----- rtl/single_wire_byte_slave_top.sv -----
// Top level of the single-wire byte slave: request registers, timing registers and core.
//
//   Channel   Direction  Handshake                Payload
//   in        input      i_in_valid / o_in_stall  i_line_level
//   out       output     o_out_valid / i_out_stall o_drive_enable, o_drive_level,
//                                                 o_byte_written, o_stored_byte, o_last_kind
//   cfg       input      i_cfg_wr_en              i_cfg_index, i_cfg_wdata
//
// One request is taken per clock unless o_in_stall is high, and its result is registered in r_out.
// The input register feeds the state machine step, whose result lands in the output register.
// A stalled output holds its result while one more request waits in the input register.
// Reset returns the frame logic to idle and the timing registers to their defaults.
module single_wire_byte_slave_top #(
    parameter int DELAY_WIDTH = sws_pkg::DELAY_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_line_level,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_drive_enable,
    output logic                            o_drive_level,
    output logic                            o_byte_written,
    output logic [7:0]                      o_stored_byte,
    output logic [1:0]                      o_last_kind,
    input  logic                            i_cfg_wr_en,
    input  logic [sws_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sws_pkg::CFG_WIDTH-1:0]   i_cfg_wdata
);

    logic                   r_in_valid;
    logic                   r_in_line;
    logic                   r_out_valid;
    sws_pkg::t_result       r_out;
    sws_pkg::t_result       w_result;
    logic                   w_step;
    logic                   w_in_take;
    logic [DELAY_WIDTH-1:0] w_short_wait;
    logic [DELAY_WIDTH-1:0] w_receive_wait;
    logic [DELAY_WIDTH-1:0] w_command_wait;
    logic [DELAY_WIDTH-1:0] w_preamble_wait;

    assign w_step     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_step;
    assign w_in_take  = i_in_valid && !o_in_stall;

    sws_cfg #(
        .DELAY_WIDTH(DELAY_WIDTH)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_short_wait   (w_short_wait),
        .o_receive_wait (w_receive_wait),
        .o_command_wait (w_command_wait),
        .o_preamble_wait(w_preamble_wait)
    );

    sws_core #(
        .DELAY_WIDTH(DELAY_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_line         (r_in_line),
        .i_short_wait   (w_short_wait),
        .i_receive_wait (w_receive_wait),
        .i_command_wait (w_command_wait),
        .i_preamble_wait(w_preamble_wait),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_line <= i_line_level;
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_drive_enable = r_out.drive_enable;
    assign o_drive_level  = r_out.drive_level;
    assign o_byte_written = r_out.byte_written;
    assign o_stored_byte  = r_out.stored_byte;
    assign o_last_kind    = r_out.last_kind;

    a_level_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_drive_enable) |-> !o_drive_level)
        else $error("Drive level set while the wire is released.");

    a_drive_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drive_enable) |-> (o_last_kind == sws_pkg::KIND_TX))
        else $error("Wire driven outside a read reply.");

    a_written_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_written) |-> (o_last_kind == sws_pkg::KIND_RX))
        else $error("Byte written pulse outside a write frame.");

    a_step_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("Processed request did not reach the output register.");

endmodule

// ----- test/tb_single_wire_byte_slave_top.sv -----
`timescale 1ns / 100ps
// Testbench for the single-wire byte slave: protocol-aware tick stimulus with line-status checks.
module tb_single_wire_byte_slave_top;
    import sws_pkg::*;

    class slave_mirror;
        t_phase                  ph;
        logic [15:0]             ticks;
        logic [2:0]              bit_idx;
        logic [7:0]              held;
        logic [1:0]              kind;
        logic [15:0]             wait_of [4];
        t_result                 status_due [$];
        int                      mismatches;

        function new();
            ph = PH_IDLE;
            ticks = '0;
            bit_idx = TOP_BIT;
            held = '0;
            kind = KIND_NONE;
            wait_of[REG_SHORT_WAIT] = 16'(RST_SHORT_WAIT);
            wait_of[REG_RECEIVE_WAIT] = 16'(RST_RECEIVE_WAIT);
            wait_of[REG_COMMAND_WAIT] = 16'(RST_COMMAND_WAIT);
            wait_of[REG_PREAMBLE_WAIT] = 16'(RST_PREAMBLE_WAIT);
            mismatches = 0;
        endfunction

        function void set_wait(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
            wait_of[idx] = val;
        endfunction

        function void go(t_phase p);
            ph = p;
            ticks = '0;
        endfunction

        function bit timer_done(logic [CFG_INDEX_W-1:0] idx);
            if (ticks != 16'hFFFF) begin
                ticks++;
            end
            return ticks >= wait_of[idx];
        endfunction

        // Advances the frame state by one accepted request and queues the line status it gives.
        function void take_tick(logic lvl);
            t_result r;
            r = '0;
            case (ph)
                PH_WAIT_RISE: if (lvl) go(PH_CMD_A);
                PH_CMD_A: begin
                    if (timer_done(REG_COMMAND_WAIT)) begin
                        if (lvl) go(PH_CMD_B_RD);
                        else go(PH_CMD_B_WR);
                    end
                end
                PH_CMD_B_RD: if (timer_done(REG_COMMAND_WAIT)) go(PH_FALL_RD);
                PH_CMD_B_WR: if (timer_done(REG_COMMAND_WAIT)) go(PH_FALL_WR);
                PH_FALL_RD: begin
                    if (!lvl) begin
                        kind = KIND_TX;
                        bit_idx = TOP_BIT;
                        go(PH_TX_PRE);
                    end
                end
                PH_FALL_WR: begin
                    if (!lvl) begin
                        kind = KIND_RX;
                        held = '0;
                        bit_idx = TOP_BIT;
                        go(PH_RX_LOW);
                    end
                end
                PH_RX_LOW: if (lvl) go(PH_RX_HIGH);
                PH_RX_HIGH: if (!lvl) go(PH_RX_SAMPLE);
                PH_RX_SAMPLE: begin
                    if (timer_done(REG_RECEIVE_WAIT)) begin
                        if (lvl) held[bit_idx] = 1'b1;
                        go(PH_RX_HOLD);
                    end
                end
                PH_RX_HOLD: if (timer_done(REG_RECEIVE_WAIT)) go(PH_RX_END_HIGH);
                PH_RX_END_HIGH: begin
                    if (!lvl) begin
                        if (bit_idx == 3'd0) begin
                            go(PH_RX_FINAL);
                        end else begin
                            bit_idx--;
                            go(PH_RX_LOW);
                        end
                    end
                end
                PH_RX_FINAL: begin
                    if (lvl) begin
                        r.byte_written = 1'b1;
                        bit_idx = TOP_BIT;
                        go(PH_IDLE);
                    end
                end
                PH_TX_PRE: if (timer_done(REG_PREAMBLE_WAIT)) go(PH_TX_L1);
                PH_TX_L1: if (timer_done(REG_SHORT_WAIT)) go(PH_TX_H1);
                PH_TX_H1: if (timer_done(REG_SHORT_WAIT)) go(PH_TX_L2);
                PH_TX_L2: if (timer_done(REG_SHORT_WAIT)) go(PH_TX_BIT);
                PH_TX_BIT: begin
                    if (timer_done(REG_SHORT_WAIT)) begin
                        if (bit_idx == 3'd0) begin
                            go(PH_TX_TAIL_H);
                        end else begin
                            bit_idx--;
                            go(PH_TX_L1);
                        end
                    end
                end
                PH_TX_TAIL_H: if (timer_done(REG_SHORT_WAIT)) go(PH_TX_TAIL_L);
                PH_TX_TAIL_L: if (timer_done(REG_SHORT_WAIT)) go(PH_TX_TAIL_H2);
                PH_TX_TAIL_H2: begin
                    if (timer_done(REG_SHORT_WAIT)) begin
                        bit_idx = TOP_BIT;
                        go(PH_IDLE);
                    end
                end
                default: begin
                    ph = PH_IDLE;
                    if (!lvl) begin
                        kind = KIND_NONE;
                        go(PH_WAIT_RISE);
                    end
                end
            endcase

            case (ph)
                PH_TX_PRE, PH_TX_H1, PH_TX_TAIL_H, PH_TX_TAIL_H2: begin
                    r.drive_enable = 1'b1;
                    r.drive_level = 1'b1;
                end
                PH_TX_L1, PH_TX_L2, PH_TX_TAIL_L: begin
                    r.drive_enable = 1'b1;
                end
                PH_TX_BIT: begin
                    r.drive_enable = 1'b1;
                    r.drive_level = held[bit_idx];
                end
                default: ;
            endcase
            r.stored_byte = held;
            r.last_kind = kind;
            status_due.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void match_status(t_result got);
            t_result want;
            if (status_due.size() == 0) begin
                $display("%0t: unexpected line status, expected none, actual %p", $time, got);
                mismatches++;
                return;
            end
            want = status_due.pop_front();
            compare_field("drive_enable", want.drive_enable, got.drive_enable);
            compare_field("drive_level", want.drive_level, got.drive_level);
            compare_field("byte_written", want.byte_written, got.byte_written);
            compare_field("stored_byte", want.stored_byte, got.stored_byte);
            compare_field("last_kind", want.last_kind, got.last_kind);
        endfunction
    endclass

    // A write frame with all waits at their minimum, stopping three bits into the byte.
    localparam logic [22:0] OPENING_TICKS = 23'b10010110_10100_10010_10110;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_line_level;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_drive_enable;
    logic                   o_drive_level;
    logic                   o_byte_written;
    logic [7:0]             o_stored_byte;
    logic [1:0]             o_last_kind;
    logic                   i_cfg_wr_en;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_WIDTH-1:0]   i_cfg_wdata;

    slave_mirror mirror = new();
    int          gap_pct;
    bit          hold_off_req;
    int          stall_left;

    single_wire_byte_slave_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_line_level   (i_line_level),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_drive_enable (o_drive_enable),
        .o_drive_level  (o_drive_level),
        .o_byte_written (o_byte_written),
        .o_stored_byte  (o_stored_byte),
        .o_last_kind    (o_last_kind),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("[single_wire_byte_slave_top] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                mirror.match_status(t_result'({o_drive_enable, o_drive_level, o_byte_written,
                                               o_stored_byte, o_last_kind}));
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left = 60;
            end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
                stall_left = $urandom_range(1, 9);
            end
            i_out_stall <= (stall_left > 0);
        end
    end

    // Mostly follows the frame protocol from the mirrored phase, with some wrong levels mixed in.
    function automatic logic next_level();
        logic lvl;
        lvl = 1'($urandom_range(0, 1));
        case (mirror.ph)
            PH_IDLE: lvl = ($urandom_range(0, 9) < 6) ? 1'b0 : 1'b1;
            PH_WAIT_RISE, PH_RX_LOW, PH_RX_FINAL: lvl = 1'b1;
            PH_FALL_RD, PH_FALL_WR, PH_RX_HIGH, PH_RX_END_HIGH: lvl = 1'b0;
            default: ;
        endcase
        if ($urandom_range(0, 99) < 15) begin
            lvl = ~lvl;
        end
        return lvl;
    endfunction

    task automatic push_tick(input logic lvl);
        i_in_valid <= 1'b1;
        i_line_level <= lvl;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        mirror.take_tick(lvl);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic run_ticks(input int count);
        repeat (count) push_tick(next_level());
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (mirror.status_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic load_waits(input logic [15:0] sw, input logic [15:0] rw,
                              input logic [15:0] cw, input logic [15:0] pw);
        logic [CFG_INDEX_W-1:0] order [4];
        logic [15:0]            vals [4];
        order = '{REG_SHORT_WAIT, REG_RECEIVE_WAIT, REG_COMMAND_WAIT, REG_PREAMBLE_WAIT};
        vals = '{sw, rw, cw, pw};
        for (int k = 0; k < 4; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= order[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            mirror.set_wait(order[k], vals[k]);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_line_level = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = REG_SHORT_WAIT;
        i_cfg_wdata = '0;
        gap_pct = 20;
        hold_off_req = 1'b0;
        stall_left = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_waits(16'd0, 16'd0, 16'd0, 16'd0);
        for (int k = 22; k >= 0; k--) begin
            push_tick(OPENING_TICKS[k]);
        end
        run_ticks(180);
        drain();

        gap_pct = 30;
        load_waits(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                   16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)));
        hold_off_req = 1'b1;
        run_ticks(200);
        drain();

        gap_pct = 10;
        load_waits(16'd1, 16'd2, 16'hFFFF, 16'd3);
        run_ticks(120);
        drain();

        // Shrinking a wait that is already running must end it on the next tick.
        load_waits(16'd2, 16'd1, 16'd1, 16'hFFFF);
        run_ticks(120);
        drain();

        load_waits(16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
        run_ticks(100);
        drain();

        gap_pct = 0;
        load_waits(16'($urandom_range(1, 3)), 16'($urandom_range(1, 3)),
                   16'($urandom_range(1, 3)), 16'($urandom_range(1, 3)));
        run_ticks(200);
        drain();

        if (mirror.mismatches == 0 && mirror.status_due.size() == 0) begin
            $display("[single_wire_byte_slave_top] OK");
        end else begin
            $display("[single_wire_byte_slave_top] ERROR");
        end
        $finish;
    end
endmodule

// ----- single_wire_byte_slave_top.f -----
rtl/sws_pkg.sv
rtl/sws_cfg.sv
rtl/sws_core.sv
rtl/single_wire_byte_slave_top.sv
test/tb_single_wire_byte_slave_top.sv
